// ----- hdl/lcd4_pkg.sv -----
// lcd4_pkg: shared types, codes, command tables for the 4-bit character LCD sequencer.
// No dependencies; used by lcd4_ctrl, lcd4_dp and char_lcd_4bit_sequencer.
`timescale 1ns / 1ps
package lcd4_pkg;

	// request codes
	localparam logic [3:0] REQ_INIT      = 4'd0;
	localparam logic [3:0] REQ_CONTROL   = 4'd1;
	localparam logic [3:0] REQ_CLEAR     = 4'd2;
	localparam logic [3:0] REQ_GOTO      = 4'd3;
	localparam logic [3:0] REQ_CHAR      = 4'd4;
	localparam logic [3:0] REQ_BACKLIGHT = 4'd5;
	localparam logic [3:0] REQ_GLYPH_BEG = 4'd6;
	localparam logic [3:0] REQ_GLYPH_ROW = 4'd7;
	localparam logic [3:0] REQ_SCROLL_L  = 4'd8;
	localparam logic [3:0] REQ_SCROLL_R  = 4'd9;

	// status codes
	localparam logic [1:0] ST_OK            = 2'd0;
	localparam logic [1:0] ST_INVALID_ARG   = 2'd1;
	localparam logic [1:0] ST_NOT_SUPPORTED = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_LINE_COUNT    = 2'd0;
	localparam logic [1:0] CFG_FONT_TALL     = 2'd1;
	localparam logic [1:0] CFG_HAS_BACKLIGHT = 2'd2;

	// controller opcodes
	localparam logic [7:0] OP_CLEAR     = 8'h01;
	localparam logic [7:0] OP_ENTRY     = 8'h04;
	localparam logic [7:0] OP_DISPCTL   = 8'h08;
	localparam logic [7:0] OP_SHIFT     = 8'h10;
	localparam logic [7:0] OP_FUNCSET   = 8'h20;
	localparam logic [7:0] OP_CGRAM     = 8'h40;
	localparam logic [7:0] OP_DDRAM     = 8'h80;
	localparam logic [7:0] FS_EIGHT_BIT = 8'h10;
	localparam logic [7:0] FS_TWO_LINES = 8'h08;
	localparam logic [7:0] FS_TALL_FONT = 8'h04;
	localparam logic [7:0] EM_INCREMENT = 8'h02;
	localparam logic [7:0] DC_DISP_ON   = 8'h04;
	localparam logic [7:0] SHIFT_RIGHT  = 8'h04;

	// hold times in microseconds
	localparam logic [12:0] WAIT_NONE   = 13'd0;
	localparam logic [12:0] WAIT_STROBE = 13'd1;
	localparam logic [12:0] WAIT_SHORT  = 13'd60;
	localparam logic [12:0] WAIT_LONG   = 13'd3000;
	localparam logic [12:0] WAIT_INIT   = 13'd5000;

	// init runs four single nibbles followed by five full bytes
	localparam logic [3:0] INIT_NIBBLES   = 4'd4;
	localparam logic [3:0] INIT_LAST_UNIT = 4'd8;

	localparam logic [7:0] LINE_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

	typedef struct packed {
		logic       accept;  // latch the incoming request
		logic       load;    // load the output register
		logic       last;    // this pin state closes the request
		logic [3:0] unit;    // nibble or byte index within the request
		logic [1:0] phase;   // 0/1 high nibble E high/low, 2/3 low nibble
	} lcd4_cmd_t;

	typedef struct packed {
		logic       single;    // one status-style result only
		logic       init_seq;  // init sequence in progress
		logic [3:0] last_unit; // index of the final unit
	} lcd4_sts_t;

	function automatic logic unit_is_nibble(input logic init_seq, input logic [3:0] unit);
		return init_seq && (unit < INIT_NIBBLES);
	endfunction

	function automatic logic [7:0] init_byte(input logic [3:0] unit, input logic [7:0] fset);
		logic [7:0] b;
		unique case (unit)
			4'd0, 4'd1, 4'd2: b = (OP_FUNCSET | FS_EIGHT_BIT) >> 4;
			4'd3:             b = OP_FUNCSET >> 4;
			4'd4:             b = fset;
			4'd5:             b = OP_DISPCTL;
			4'd6:             b = OP_CLEAR;
			4'd7:             b = OP_ENTRY | EM_INCREMENT;
			default:          b = OP_DISPCTL | DC_DISP_ON;
		endcase
		return b;
	endfunction

	function automatic logic [12:0] init_wait(input logic [3:0] unit);
		logic [12:0] w;
		unique case (unit)
			4'd0, 4'd1, 4'd2: w = WAIT_INIT;
			4'd6:             w = WAIT_LONG;
			default:          w = WAIT_SHORT;
		endcase
		return w;
	endfunction

endpackage

// ----- hdl/lcd4_if.sv -----
// lcd4_if: request, pin-state and configuration channels of the LCD sequencer.
// No dependencies.
`timescale 1ns / 1ps
interface lcd4_req_if;
	logic       valid;
	logic       ready;
	logic [3:0] req_type;
	logic       switch_on;
	logic       cursor_on;
	logic       blink_on;
	logic [5:0] column;
	logic [2:0] text_line;
	logic [3:0] glyph;
	logic [7:0] byte_value;

	modport source(output valid, req_type, switch_on, cursor_on, blink_on, column,
		text_line, glyph, byte_value, input ready);
	modport sink(input valid, req_type, switch_on, cursor_on, blink_on, column,
		text_line, glyph, byte_value, output ready);
endinterface

interface lcd4_pins_if;
	logic        valid;
	logic        ready;
	logic        reg_select;
	logic        enable;
	logic [3:0]  nibble;
	logic        backlight_pin;
	logic [12:0] wait_us;
	logic [1:0]  status;
	logic        last;

	modport source(output valid, reg_select, enable, nibble, backlight_pin, wait_us,
		status, last, input ready);
	modport sink(input valid, reg_select, enable, nibble, backlight_pin, wait_us,
		status, last, output ready);
endinterface

interface lcd4_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [2:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/lcd4_ctrl.sv -----
// lcd4_ctrl: sequencer state machine; steps unit and phase, owns the output valid.
// Depends on lcd4_pkg.
`timescale 1ns / 1ps
module lcd4_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lcd4_pkg::lcd4_cmd_t   cmd,
	input  lcd4_pkg::lcd4_sts_t   sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_RUN
	} state_t;

	state_t     state_q;
	logic       out_valid_q;
	logic [3:0] unit_q;
	logic [1:0] phase_q;
	logic       adv;
	logic       last_state;
	logic [3:0] next_unit;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign adv        = !out_valid_q || out_ready;
	assign last_state = sts.single || ((unit_q == sts.last_unit) && (phase_q == 2'd3));
	assign next_unit  = unit_q + 4'd1;

	always_comb begin
		cmd.accept = in_valid && in_ready;
		cmd.load   = (state_q == S_RUN) && adv;
		cmd.last   = last_state;
		cmd.unit   = unit_q;
		cmd.phase  = phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			unit_q      <= '0;
			phase_q     <= '0;
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					// single nibbles skip the high-nibble phases
					unit_q  <= '0;
					phase_q <= lcd4_pkg::unit_is_nibble(sts.init_seq, 4'd0) ? 2'd2 : 2'd0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (adv) begin
						if (last_state) begin
							state_q <= S_IDLE;
						end else if (phase_q == 2'd3) begin
							unit_q  <= next_unit;
							phase_q <= lcd4_pkg::unit_is_nibble(sts.init_seq, next_unit)
								? 2'd2 : 2'd0;
						end else begin
							phase_q <= phase_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && cmd.last |=> state_q == S_IDLE)
		else $error("sequencer kept running after the final pin state");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) && !sts.single |-> unit_q <= sts.last_unit)
		else $error("unit index ran past the last unit");

	a_nibble_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) && lcd4_pkg::unit_is_nibble(sts.init_seq, unit_q) |-> phase_q[1])
		else $error("single nibble unit sent a high-nibble phase");

	a_no_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !cmd.load)
		else $error("output loaded before the request was decoded");

endmodule

// ----- hdl/lcd4_dp.sv -----
// lcd4_dp: request decode, config and display state registers, pin-state output register.
// Depends on lcd4_pkg.
`timescale 1ns / 1ps
module lcd4_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcd4_pkg::lcd4_cmd_t  cmd,
	output lcd4_pkg::lcd4_sts_t  sts,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [2:0]           cfg_data,
	input  logic [3:0]           req_type,
	input  logic                 switch_on,
	input  logic                 cursor_on,
	input  logic                 blink_on,
	input  logic [5:0]           column,
	input  logic [2:0]           text_line,
	input  logic [3:0]           glyph,
	input  logic [7:0]           byte_value,
	output logic                 reg_select,
	output logic                 enable,
	output logic [3:0]           nibble,
	output logic                 backlight_pin,
	output logic [12:0]          wait_us,
	output logic [1:0]           status,
	output logic                 last
);

	// configuration and display state
	logic [2:0] line_count_q;
	logic       font_tall_q;
	logic       has_bl_q;
	logic       bl_q;
	logic [3:0] rows_left_q;

	// latched request plan
	logic       single_q;
	logic [1:0] status_q;
	logic       init_q;
	logic [3:0] last_unit_q;
	logic [7:0] byte0_q;
	logic       rs0_q;
	logic       long0_q;

	// output register
	logic        rs_q;
	logic        e_q;
	logic [3:0]  nib_q;
	logic        blp_q;
	logic [12:0] wait_q;
	logic [1:0]  st_q;
	logic        last_q;

	// decode
	logic       d_single;
	logic [1:0] d_status;
	logic       d_init;
	logic [3:0] d_last_unit;
	logic [7:0] d_byte;
	logic       d_rs;
	logic       d_long;
	logic       d_set_bl;
	logic       d_load_rows;
	logic       d_dec_rows;
	logic [3:0] rows;
	logic [7:0] fset;

	// unit datapath
	logic [7:0]  u_byte;
	logic        u_rs;
	logic [12:0] u_end_wait;
	logic [12:0] ph_wait;

	assign rows = font_tall_q ? 4'd10 : 4'd8;
	assign fset = lcd4_pkg::OP_FUNCSET
		| ((line_count_q > 3'd1) ? lcd4_pkg::FS_TWO_LINES : 8'h00)
		| (font_tall_q ? lcd4_pkg::FS_TALL_FONT : 8'h00);

	always_comb begin
		d_single    = 1'b0;
		d_status    = lcd4_pkg::ST_OK;
		d_init      = 1'b0;
		d_last_unit = 4'd0;
		d_byte      = 8'h00;
		d_rs        = 1'b0;
		d_long      = 1'b0;
		d_set_bl    = 1'b0;
		d_load_rows = 1'b0;
		d_dec_rows  = 1'b0;
		unique case (req_type)
			lcd4_pkg::REQ_INIT: begin
				if (line_count_q == 3'd0 || line_count_q > 3'd4) begin
					d_single = 1'b1;
					d_status = lcd4_pkg::ST_INVALID_ARG;
				end else begin
					d_init      = 1'b1;
					d_last_unit = lcd4_pkg::INIT_LAST_UNIT;
				end
			end
			lcd4_pkg::REQ_CONTROL: begin
				d_byte = lcd4_pkg::OP_DISPCTL | {5'b0, switch_on, cursor_on, blink_on};
			end
			lcd4_pkg::REQ_CLEAR: begin
				d_byte = lcd4_pkg::OP_CLEAR;
				d_long = 1'b1;
			end
			lcd4_pkg::REQ_GOTO: begin
				if (text_line >= line_count_q || text_line[2]) begin
					d_single = 1'b1;
					d_status = lcd4_pkg::ST_INVALID_ARG;
				end else begin
					// address wraps modulo 256
					d_byte = lcd4_pkg::OP_DDRAM + lcd4_pkg::LINE_BASE[text_line[1:0]]
						+ {2'b00, column};
				end
			end
			lcd4_pkg::REQ_CHAR: begin
				d_byte = byte_value;
				d_rs   = 1'b1;
			end
			lcd4_pkg::REQ_BACKLIGHT: begin
				d_single = 1'b1;
				if (!has_bl_q) begin
					d_status = lcd4_pkg::ST_NOT_SUPPORTED;
				end else begin
					d_set_bl = 1'b1;
				end
			end
			lcd4_pkg::REQ_GLYPH_BEG: begin
				if (glyph[3]) begin
					d_single = 1'b1;
					d_status = lcd4_pkg::ST_INVALID_ARG;
				end else begin
					// glyph * rows as glyph*8 plus glyph*2 for the tall font
					d_byte = lcd4_pkg::OP_CGRAM + {2'b00, glyph[2:0], 3'b000}
						+ (font_tall_q ? {4'b0000, glyph[2:0], 1'b0} : 8'h00);
					d_load_rows = 1'b1;
				end
			end
			lcd4_pkg::REQ_GLYPH_ROW: begin
				if (rows_left_q == 4'd0) begin
					d_single = 1'b1;
					d_status = lcd4_pkg::ST_INVALID_ARG;
				end else begin
					d_byte      = byte_value;
					d_rs        = 1'b1;
					d_dec_rows  = 1'b1;
					// final row appends a home move
					d_last_unit = (rows_left_q == 4'd1) ? 4'd1 : 4'd0;
				end
			end
			lcd4_pkg::REQ_SCROLL_L: begin
				d_byte = lcd4_pkg::OP_SHIFT | lcd4_pkg::OP_DISPCTL;
			end
			lcd4_pkg::REQ_SCROLL_R: begin
				d_byte = lcd4_pkg::OP_SHIFT | lcd4_pkg::OP_DISPCTL | lcd4_pkg::SHIFT_RIGHT;
			end
			default: begin
				d_single = 1'b1;
				d_status = lcd4_pkg::ST_INVALID_ARG;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= 3'd2;
			font_tall_q  <= 1'b0;
			has_bl_q     <= 1'b1;
			bl_q         <= 1'b0;
			rows_left_q  <= 4'd0;
			single_q     <= 1'b0;
			init_q       <= 1'b0;
			last_unit_q  <= 4'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lcd4_pkg::CFG_LINE_COUNT:    line_count_q <= cfg_data;
					lcd4_pkg::CFG_FONT_TALL:     font_tall_q  <= cfg_data[0];
					lcd4_pkg::CFG_HAS_BACKLIGHT: has_bl_q     <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				single_q    <= d_single;
				init_q      <= d_init;
				last_unit_q <= d_last_unit;
				if (d_set_bl) begin
					bl_q <= switch_on;
				end
				if (d_load_rows) begin
					rows_left_q <= rows;
				end else if (d_dec_rows) begin
					rows_left_q <= rows_left_q - 4'd1;
				end
			end
		end
	end

	// plan payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			status_q <= d_status;
			byte0_q  <= d_byte;
			rs0_q    <= d_rs;
			long0_q  <= d_long;
		end
	end

	always_comb begin
		if (init_q) begin
			u_byte     = lcd4_pkg::init_byte(cmd.unit, fset);
			u_rs       = 1'b0;
			u_end_wait = lcd4_pkg::init_wait(cmd.unit);
		end else if (!cmd.unit[0]) begin
			u_byte     = byte0_q;
			u_rs       = rs0_q;
			u_end_wait = long0_q ? lcd4_pkg::WAIT_LONG : lcd4_pkg::WAIT_SHORT;
		end else begin
			u_byte     = lcd4_pkg::OP_DDRAM;
			u_rs       = 1'b0;
			u_end_wait = lcd4_pkg::WAIT_SHORT;
		end
		if (!cmd.phase[0]) begin
			ph_wait = lcd4_pkg::WAIT_STROBE;
		end else if (cmd.phase[1]) begin
			ph_wait = u_end_wait;
		end else begin
			ph_wait = lcd4_pkg::WAIT_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			blp_q  <= bl_q;
			last_q <= cmd.last;
			if (single_q) begin
				rs_q   <= 1'b0;
				e_q    <= 1'b0;
				nib_q  <= 4'd0;
				wait_q <= lcd4_pkg::WAIT_NONE;
				st_q   <= status_q;
			end else begin
				rs_q   <= u_rs;
				e_q    <= !cmd.phase[0];
				nib_q  <= cmd.phase[1] ? u_byte[3:0] : u_byte[7:4];
				wait_q <= ph_wait;
				st_q   <= lcd4_pkg::ST_OK;
			end
		end
	end

	always_comb begin
		sts.single    = single_q;
		sts.init_seq  = init_q;
		sts.last_unit = last_unit_q;
	end

	assign reg_select    = rs_q;
	assign enable        = e_q;
	assign nibble        = nib_q;
	assign backlight_pin = blp_q;
	assign wait_us       = wait_q;
	assign status        = st_q;
	assign last          = last_q;

endmodule

// ----- hdl/char_lcd_4bit_sequencer.sv -----
// char_lcd_4bit_sequencer: top level of the 4-bit character LCD pin sequencer.
// Depends on lcd4_pkg, lcd4_if, lcd4_ctrl and lcd4_dp.
`timescale 1ns / 1ps

// Each request item on req turns into a run of pin-state items on pins: a byte goes out
// as four states (high nibble with E high, E low, then the low nibble the same way),
// each carrying rs, the backlight level and the hold time in microseconds, which the
// downstream driver times out. Init yields 28 states, a glyph row that closes an upload
// yields 8 (the row plus a move home), other bus requests 4, and backlight or rejected
// requests a single state whose status field says ok, invalid_arg or not_supported.
// The sequencer handles one request at a time and, while pins is not stalled, emits one
// pin state per cycle within a request: the request plan is latched when it is taken in
// the idle state, the prep state sets up the first unit, then its states follow in order. The next request is
// taken as soon as the final state sits in the output register, even if it has not
// been taken yet. cfg is always ready; write it only while the block is idle. Index 0
// sets line_count, 1 font_tall, 2 has_backlight_pin; other indexes are ignored.
module char_lcd_4bit_sequencer (
	input  logic         clk,
	input  logic         arst_n,
	lcd4_req_if.sink     req,
	lcd4_pins_if.source  pins,
	lcd4_cfg_if.sink     cfg
);

	lcd4_pkg::lcd4_cmd_t cmd;
	lcd4_pkg::lcd4_sts_t sts;

	// configuration writes never stall
	assign cfg.ready = 1'b1;

	// controller: handshakes and unit/phase stepping
	lcd4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (pins.valid),
		.out_ready (pins.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath: decode, state registers, pin-state output register
	lcd4_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.req_type      (req.req_type),
		.switch_on     (req.switch_on),
		.cursor_on     (req.cursor_on),
		.blink_on      (req.blink_on),
		.column        (req.column),
		.text_line     (req.text_line),
		.glyph         (req.glyph),
		.byte_value    (req.byte_value),
		.reg_select    (pins.reg_select),
		.enable        (pins.enable),
		.nibble        (pins.nibble),
		.backlight_pin (pins.backlight_pin),
		.wait_us       (pins.wait_us),
		.status        (pins.status),
		.last          (pins.last)
	);

endmodule
